@@ sv/sha256_stream_hasher_top_assert.svh @@
// Assertion macros shared by the hasher modules.
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ sv/sha_pkg.sv @@
// Package: SHA-256 constants, command and status types, and helper functions.
`timescale 1ns / 1ps
package sha_pkg;
	localparam int unsigned WordW = 32;
	localparam int unsigned BlockBytes = 64;
	localparam int unsigned Rounds = 64;
	localparam logic [7:0] PadByte = 8'h80;

	typedef logic [WordW-1:0] word_t;

	localparam word_t InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam word_t RoundConst [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	// byte write sources
	localparam logic [1:0] SrcMsg = 2'd0;
	localparam logic [1:0] SrcPad = 2'd1;
	localparam logic [1:0] SrcZero = 2'd2;
	localparam logic [1:0] SrcLen = 2'd3;

	typedef struct packed {
		logic       wr_en;       // write one byte at pos
		logic [1:0] wr_src;
		logic       cnt_bump;    // add 8 to bit length
		logic       cmp_start;   // begin compression of buffer
		logic       reinit;      // restore initial hash and lengths
		logic       pos_clear;   // pos back to zero
	} sha_cmd_t;

	typedef struct packed {
		logic [5:0] pos;
		logic       cmp_busy;
		logic       cmp_done;
	} sha_sts_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t sig0(input word_t x);
		sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction
endpackage

@@ sv/sha_dp.sv @@
// Datapath: block buffer, bit length, message schedule and one-round-per-cycle compressor.
`timescale 1ns / 1ps
module sha_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  sha_pkg::sha_cmd_t cmd,
	input  logic [7:0]        msg_byte,
	input  logic [2:0]        rd_idx,
	output sha_pkg::word_t    rd_word,
	output sha_pkg::sha_sts_t sts
);
	import sha_pkg::*;

	logic [5:0]  pos_q;
	logic [63:0] bits_q;
	word_t       h_q [8];
	word_t       v_q [8];
	word_t       w_q [16];
	logic [5:0]  rnd_q;
	logic        busy_q;
	logic        done_q;
	logic [7:0]  wr_data;
	word_t       t1, t2, wt, wnew;
	logic [2:0]  len_sel;

	assign len_sel = 3'(~pos_q[2:0]);

	always_comb begin
		unique case (cmd.wr_src)
			SrcMsg:  wr_data = msg_byte;
			SrcPad:  wr_data = PadByte;
			SrcZero: wr_data = 8'h00;
			SrcLen:  wr_data = bits_q[{len_sel, 3'b000} +: 8];
			default: wr_data = 8'h00;
		endcase
	end

	// schedule window: w_q[0] is W[t]
	assign wt = w_q[0];
	assign wnew = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
	assign t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundConst[rnd_q] + wt;
	assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			bits_q <= '0;
			rnd_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
		end else begin
			done_q <= busy_q && !cmd.cmp_start && (rnd_q == 6'(Rounds - 1));
			if (cmd.pos_clear)
				pos_q <= '0;
			else if (cmd.wr_en)
				pos_q <= pos_q + 6'd1;
			if (cmd.cnt_bump)
				bits_q <= bits_q + 64'd8;
			if (cmd.reinit) begin
				bits_q <= '0;
				pos_q <= '0;
				for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
			end
			if (cmd.cmp_start) begin
				busy_q <= 1'b1;
				rnd_q <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'(Rounds - 1)) begin
					busy_q <= 1'b0;
					h_q[0] <= h_q[0] + t1 + t2;
					h_q[1] <= h_q[1] + v_q[0];
					h_q[2] <= h_q[2] + v_q[1];
					h_q[3] <= h_q[3] + v_q[2];
					h_q[4] <= h_q[4] + v_q[3] + t1;
					h_q[5] <= h_q[5] + v_q[4];
					h_q[6] <= h_q[6] + v_q[5];
					h_q[7] <= h_q[7] + v_q[6];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp_start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (busy_q) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		// fill shifts bytes in from the bottom; after 64 bytes byte 0 sits in w_q[0][31:24]
		if (cmd.wr_en) begin
			for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			w_q[15] <= {w_q[15][23:0], wr_data};
		end else if (busy_q) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end
	end

	assign rd_word = h_q[rd_idx];
	assign sts.pos = pos_q;
	assign sts.cmp_busy = busy_q;
	assign sts.cmp_done = done_q;

	`include "sha256_stream_hasher_top_assert.svh"
	`SHA_ASSERT_IMP(a_no_start_busy, clk, arst_n, cmd.cmp_start, !busy_q,
		"compression started while busy")
	`SHA_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q,
		"done held more than one cycle")
	`SHA_ASSERT_IMP(a_no_wr_busy, clk, arst_n, busy_q, !cmd.wr_en,
		"buffer written during compression")
endmodule

@@ sv/sha_ctrl.sv @@
// Controller: input handshake, padding sequence, compression launch and digest output.
`timescale 1ns / 1ps
module sha_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              byte_present,
	input  logic              end_of_message,
	input  sha_pkg::sha_sts_t sts,
	output sha_pkg::sha_cmd_t cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        out_idx
);
	import sha_pkg::*;

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StCmp = 3'd1;
	localparam logic [2:0] StPad = 3'd2;
	localparam logic [2:0] StZero = 3'd3;
	localparam logic [2:0] StLen = 3'd4;
	localparam logic [2:0] StOut = 3'd5;

	logic [2:0] state_q;
	logic       fin_q;    // compression belongs to the closing sequence
	logic       last_q;   // compression is the final block
	logic       pad_q;    // pad byte already written
	logic [2:0] idx_q;
	logic       acc;

	assign in_ready = (state_q == StIdle);
	assign acc = in_valid && in_ready;
	assign out_valid = (state_q == StOut);
	assign out_idx = idx_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			StIdle: begin
				if (acc && byte_present) begin
					cmd.wr_en = 1'b1;
					cmd.wr_src = SrcMsg;
					cmd.cnt_bump = 1'b1;
					cmd.cmp_start = (sts.pos == 6'd63);
				end
			end
			StPad: begin
				cmd.wr_en = 1'b1;
				cmd.wr_src = SrcPad;
				cmd.cmp_start = (sts.pos == 6'd63);
			end
			StZero: begin
				cmd.wr_en = 1'b1;
				cmd.wr_src = SrcZero;
				// block full: compress and restart fill
				cmd.cmp_start = (sts.pos == 6'd63);
			end
			StLen: begin
				cmd.wr_en = 1'b1;
				cmd.wr_src = SrcLen;
				cmd.cmp_start = (sts.pos == 6'd63);
			end
			StOut: cmd.reinit = out_ready && (idx_q == 3'd7);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			fin_q <= 1'b0;
			last_q <= 1'b0;
			pad_q <= 1'b0;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				StIdle: if (acc) begin
					fin_q <= end_of_message;
					last_q <= 1'b0;
					pad_q <= 1'b0;
					if (byte_present && sts.pos == 6'd63)
						state_q <= StCmp;
					else if (end_of_message)
						state_q <= StPad;
				end
				StCmp: if (sts.cmp_done) begin
					if (last_q) begin
						idx_q <= '0;
						state_q <= StOut;
					end else if (fin_q) begin
						state_q <= pad_q ? StZero : StPad;
					end else begin
						state_q <= StIdle;
					end
				end
				StPad: begin
					pad_q <= 1'b1;
					if (sts.pos == 6'd63) state_q <= StCmp;
					else if (sts.pos == 6'd55) state_q <= StLen;
					else state_q <= StZero;
				end
				StZero: begin
					if (sts.pos == 6'd63) state_q <= StCmp;
					else if (sts.pos == 6'd55) state_q <= StLen;
				end
				StLen: if (sts.pos == 6'd63) begin
					last_q <= 1'b1;
					state_q <= StCmp;
				end
				StOut: if (out_ready) begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7) state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	`include "sha256_stream_hasher_top_assert.svh"
	`SHA_ASSERT_IMP(a_out_no_busy, clk, arst_n, out_valid, !sts.cmp_busy,
		"digest shown during compression")
	`SHA_ASSERT_IMP(a_len_pos, clk, arst_n, state_q == StLen, sts.pos >= 6'd56,
		"length written outside its slot")
	`SHA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid,
		"digest item dropped while stalled")
endmodule

@@ sv/sha256_stream_hasher_top.sv @@
// Top level: streaming SHA-256 hasher.
`timescale 1ns / 1ps
// Takes one message byte per item (tlast closes the message) and returns the eight
// digest words H0..H7 as eight items. The 64th byte of a block starts a 64-round
// compression (one round per cycle in the datapath) that holds off the input until
// it is done. Closing a message writes padding one byte a cycle between compressions
// (at most 72 writes, with one or two compressions), then the words are shown one
// per cycle while tready.
module sha256_stream_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] msg_byte
	input  logic        s_tuser,   // byte_present
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
	output logic        m_tlast    // last_word
);
	import sha_pkg::*;

	sha_cmd_t   cmd;
	sha_sts_t   sts;
	logic [2:0] idx;
	word_t      word;

	sha_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.byte_present(s_tuser), .end_of_message(s_tlast),
		.sts, .cmd,
		.out_valid(m_tvalid), .out_ready(m_tready), .out_idx(idx)
	);

	sha_dp u_dp (
		.clk, .arst_n, .cmd, .msg_byte(s_tdata),
		.rd_idx(idx), .rd_word(word), .sts
	);

	assign m_tdata = {5'b0, idx, word};
	assign m_tlast = (idx == 3'd7);
endmodule

@@ verif/sha256_stream_hasher_top_tb.sv @@
// Testbench for the streaming SHA-256 hasher: directed table plus random messages.
`timescale 1ns / 1ps
module sha256_stream_hasher_top_tb;
	import sha_pkg::*;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       present;
		logic       eom;
	} byte_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_item_t;

	localparam int unsigned IdleLimit = 20000;
	localparam int unsigned TailCycles = 300;
	localparam int BoundLen [4] = '{55, 56, 63, 64};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;

	sha256_stream_hasher_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// predictor state
	word_t       hash_state [8];
	logic [7:0]  blk_bytes [64];
	logic [5:0]  blk_fill;
	logic [63:0] bit_len;

	digest_item_t digest_q [$];
	int unsigned  fail_cnt;
	int unsigned  idle_cycles;

	// directed stimulus: empty message, "abc", idles, extremes
	byte_item_t   dir_items [$];
	digest_item_t known_digest [8];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic word_t ror32(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic run_block();
		word_t w [64];
		word_t v [8];
		word_t t1;
		word_t t2;
		for (int t = 0; t < 16; t++)
			w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = w[t-16] + w[t-7]
				+ (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
				+ (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10));
		v = hash_state;
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w[t];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int k = 0; k < 8; k++)
			hash_state[k] += v[k];
	endtask

	task automatic restart_hash();
		hash_state = InitHash;
		blk_fill = '0;
		bit_len = '0;
	endtask

	task automatic absorb_item(input byte_item_t it);
		int pos;
		digest_item_t d;
		if (it.present) begin
			blk_bytes[blk_fill] = it.msg_byte;
			bit_len += 64'd8;
			blk_fill++;
			if (blk_fill == 0)
				run_block();
		end
		if (!it.eom)
			return;
		pos = blk_fill;
		blk_bytes[pos++] = PadByte;
		if (pos > 56) begin
			while (pos < 64)
				blk_bytes[pos++] = 8'h00;
			run_block();
			pos = 0;
		end
		while (pos < 56)
			blk_bytes[pos++] = 8'h00;
		for (int k = 7; k >= 0; k--)
			blk_bytes[pos++] = bit_len[8*k +: 8];
		run_block();
		for (int k = 0; k < 8; k++) begin
			d.digest_word = hash_state[k];
			d.word_index = 3'(k);
			d.last_word = (k == 7);
			digest_q.push_back(d);
		end
		restart_hash();
	endtask

	// send one item, idling first for a random gap when asked
	task automatic send_item(input byte_item_t it, input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= it.msg_byte;
		s_tuser <= it.present;
		s_tlast <= it.eom;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		absorb_item(it);
	endtask

	task automatic send_burst(input byte_item_t it, inout int burst_left);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
		end
		burst_left--;
		send_item(it, gap);
	endtask

	// receiver: stall pattern changes from stretch to stretch
	initial begin
		int mode;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(20, 200)) begin
				@(posedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					2: m_tready <= ($urandom_range(0, 7) == 0);
					default: m_tready <= ~m_tready;
				endcase
			end
		end
	end

	// checker and watchdog
	always @(posedge clk) begin
		digest_item_t got;
		digest_item_t want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("tb: failure");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				got.digest_word = m_tdata[31:0];
				got.word_index = m_tdata[34:32];
				got.last_word = m_tlast;
				if (digest_q.size() == 0) begin
					$error("unexpected digest item %h", m_tdata);
					fail_cnt++;
				end else begin
					want = digest_q.pop_front();
					if (got.digest_word !== want.digest_word) begin
						$error("digest_word exp %h got %h", want.digest_word, got.digest_word);
						fail_cnt++;
					end
					if (got.word_index !== want.word_index) begin
						$error("word_index exp %0d got %0d", want.word_index, got.word_index);
						fail_cnt++;
					end
					if (got.last_word !== want.last_word) begin
						$error("last_word exp %0d got %0d", want.last_word, got.last_word);
						fail_cnt++;
					end
					if (m_tdata[39:35] !== 5'd0) begin
						$error("fill bits exp 0 got %h", m_tdata[39:35]);
						fail_cnt++;
					end
				end
			end
		end
	end

	task automatic build_directed();
		byte_item_t it;
		// empty message
		it = '{msg_byte: 8'h5a, present: 1'b0, eom: 1'b1}; dir_items.push_back(it);
		// "abc" with an idle item inside and the last byte riding with the end
		it = '{msg_byte: 8'h61, present: 1'b1, eom: 1'b0}; dir_items.push_back(it);
		it = '{msg_byte: 8'hff, present: 1'b0, eom: 1'b0}; dir_items.push_back(it);
		it = '{msg_byte: 8'h62, present: 1'b1, eom: 1'b0}; dir_items.push_back(it);
		it = '{msg_byte: 8'h63, present: 1'b1, eom: 1'b1}; dir_items.push_back(it);
		// byte extremes, closed by an empty end marker
		it = '{msg_byte: 8'h00, present: 1'b1, eom: 1'b0}; dir_items.push_back(it);
		it = '{msg_byte: 8'hff, present: 1'b1, eom: 1'b0}; dir_items.push_back(it);
		it = '{msg_byte: 8'haa, present: 1'b1, eom: 1'b0}; dir_items.push_back(it);
		it = '{msg_byte: 8'h55, present: 1'b1, eom: 1'b0}; dir_items.push_back(it);
		it = '{msg_byte: 8'h00, present: 1'b0, eom: 1'b1}; dir_items.push_back(it);
		// single 0xff byte with end
		it = '{msg_byte: 8'hff, present: 1'b1, eom: 1'b1}; dir_items.push_back(it);
		// empty message again right after a digest
		it = '{msg_byte: 8'h00, present: 1'b0, eom: 1'b1}; dir_items.push_back(it);
	endtask

	// send a message of given length; closing style picked at random
	task automatic send_message(input int len, inout int burst_left);
		byte_item_t it;
		bit fold_end;
		fold_end = $urandom_range(0, 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0) begin
				it = '{msg_byte: 8'($urandom), present: 1'b0, eom: 1'b0};
				send_burst(it, burst_left);
			end
			it.msg_byte = 8'($urandom);
			it.present = 1'b1;
			it.eom = fold_end && (i == len - 1);
			send_burst(it, burst_left);
		end
		if (!fold_end || len == 0) begin
			it = '{msg_byte: 8'($urandom), present: 1'b0, eom: 1'b1};
			send_burst(it, burst_left);
		end
	endtask

	initial begin
		int burst_left;
		int sent;
		int len;
		int sel;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		fail_cnt = 0;
		idle_cycles = 0;
		burst_left = 0;
		restart_hash();
		for (int i = 0; i < 64; i++)
			blk_bytes[i] = 8'h00;
		known_digest = '{
			'{32'hba7816bf, 3'd0, 1'b0}, '{32'h8f01cfea, 3'd1, 1'b0},
			'{32'h414140de, 3'd2, 1'b0}, '{32'h5dae2223, 3'd3, 1'b0},
			'{32'hb00361a3, 3'd4, 1'b0}, '{32'h96177a9c, 3'd5, 1'b0},
			'{32'hb410ff61, 3'd6, 1'b0}, '{32'hf20015ad, 3'd7, 1'b1}};
		build_directed();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_items[i]) begin
			send_burst(dir_items[i], burst_left);
			// "abc" digest is the standard one: cross-check the predictor
			if (i == 4)
				foreach (known_digest[k])
					if (digest_q[digest_q.size() - 8 + k] !== known_digest[k]) begin
						$error("abc digest word %0d exp %h got %h", k,
							known_digest[k], digest_q[digest_q.size() - 8 + k]);
						fail_cnt++;
					end
		end
		// message lengths around the padding boundaries
		for (int i = 0; i < 4; i++)
			send_message(BoundLen[i], burst_left);

		s_tvalid <= 1'b0;
		// hold off until every digest is out
		while (digest_q.size() != 0)
			@(posedge clk);

		sent = 0;
		while (sent < 100) begin
			sel = $urandom_range(0, 9);
			if (sel < 6)
				len = $urandom_range(0, 20);
			else if (sel < 9)
				len = $urandom_range(50, 70);
			else
				len = $urandom_range(100, 140);
			send_message(len, burst_left);
			sent += len + 1;
		end
		s_tvalid <= 1'b0;

		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);
		if (fail_cnt == 0 && digest_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
